// ===== rtl/upf_pkg.sv =====
// Shared types, widths and codes of the UDP payload pattern filter.
`timescale 1ns / 1ps
`default_nettype none

package upf_pkg;

  localparam int MAX_PATTERN   = 32;
  localparam int UDP_HDR_BYTES = 8;
  localparam int PAT_WORDS     = 4;

  localparam int BYTE_W   = 8;
  localparam int IHL_W    = 6;
  localparam int PLEN_W   = 6;
  localparam int PIDX_W   = $clog2(MAX_PATTERN);
  localparam int CFG_DW   = 64;
  localparam int CFG_IW   = 3;
  localparam int HDR_W    = IHL_W + 1;
  localparam int SEEN_W   = $clog2(MAX_PATTERN + 1);
  // Byte position matters only up to the largest header end; its count saturates at max.
  localparam int BIDX_W   = HDR_W;

  typedef enum logic [1:0] {
    VERDICT_BLOCK    = 2'd0,
    VERDICT_CONTINUE = 2'd1,
    VERDICT_NONE     = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    MODE_BLOCK_ALL = 2'd0,
    MODE_INSPECT   = 2'd1,
    MODE_PASS_ALL  = 2'd2
  } filter_mode_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_FILTER_MODE  = 3'd0,
    REG_REPLACE_MODE = 3'd1,
    REG_PATTERN_LEN  = 3'd2,
    REG_PATTERN_W0   = 3'd3,
    REG_PATTERN_W1   = 3'd4,
    REG_PATTERN_W2   = 3'd5,
    REG_PATTERN_W3   = 3'd6
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/upf_if.sv =====
// Valid/ready channel interfaces for packet bytes in and verdicts out.
`timescale 1ns / 1ps
`default_nettype none

interface upf_in_if import upf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pkt_byte;
  logic [IHL_W-1:0]  ip_header_len;
  logic              last_byte;

  modport source (output valid, output pkt_byte, output ip_header_len, output last_byte,
                  input ready);
  modport sink   (input valid, input pkt_byte, input ip_header_len, input last_byte,
                  output ready);
endinterface

interface upf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

// ===== rtl/udp_payload_pattern_filter_unit.sv =====
// Top level of the UDP payload pattern filter: byte scan, window compare and verdict.
// Path: an accepted byte waits in the input register for its scan; a last byte's verdict
//   is registered in the result register and held until the sink takes it.
// Throughput: one byte per cycle, set by the 32-byte compare, unless a verdict is stalled.
// Reset: rst_n is synchronous, active low; it restores register defaults (mode block all,
//   pattern length 1, pattern zero) and clears the per-packet counters, match flag and valids.
`timescale 1ns / 1ps
`default_nettype none

module udp_payload_pattern_filter_unit import upf_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  upf_in_if.sink             in_ch,
  upf_out_if.source          out_ch,
  input  wire                cfg_we,
  input  wire [CFG_IW-1:0]   cfg_index,
  input  wire [CFG_DW-1:0]   cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]        filter_mode_r;
  logic              replace_mode_r;
  logic [PLEN_W-1:0] pattern_len_r;
  logic [CFG_DW-1:0] pat_word_r [PAT_WORDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r  <= MODE_BLOCK_ALL;
      replace_mode_r <= 1'b0;
      pattern_len_r  <= PLEN_W'(1);
      for (int w = 0; w < PAT_WORDS; w++) begin
        pat_word_r[w] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FILTER_MODE:  filter_mode_r  <= cfg_data[1:0];
        REG_REPLACE_MODE: replace_mode_r <= cfg_data[0];
        REG_PATTERN_LEN:  pattern_len_r  <= cfg_data[PLEN_W-1:0];
        REG_PATTERN_W0:   pat_word_r[0]  <= cfg_data;
        REG_PATTERN_W1:   pat_word_r[1]  <= cfg_data;
        REG_PATTERN_W2:   pat_word_r[2]  <= cfg_data;
        REG_PATTERN_W3:   pat_word_r[3]  <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: one packet byte waits here for the scan cycle
  // ---------------------------------------------------------------------------
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [IHL_W-1:0]  s1_ihl_r;
  logic              s1_last_r;
  logic              out_valid_r;
  logic [1:0]        verdict_r;
  logic              fire;

  // The scan cycle may proceed unless it would produce a verdict into a full, stalled output.
  assign fire        = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.pkt_byte;
      s1_ihl_r  <= in_ch.ip_header_len;
      s1_last_r <= in_ch.last_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-packet scan state
  // ---------------------------------------------------------------------------
  logic [BIDX_W-1:0] byte_idx_r;
  logic [SEEN_W-1:0] seen_r;
  logic              match_r;
  logic [BYTE_W-1:0] win_r [MAX_PATTERN];   // entry 0 is the newest payload byte

  logic [HDR_W-1:0]       hdr_end;
  logic                   is_payload;
  logic [BIDX_W-1:0]      byte_idx_nxt;
  logic [SEEN_W-1:0]      seen_inc;
  logic [PLEN_W-1:0]      eff_len;
  logic [PIDX_W-1:0]      len_m1;
  logic [PIDX_W-1:0]      pidx [MAX_PATTERN];
  logic [BYTE_W-1:0]      nwin [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] pos_ok;
  logic [PAT_WORDS*CFG_DW-1:0] pat_flat;
  logic                   hit;
  logic                   match_any;
  logic [1:0]             verdict_nxt;

  assign pat_flat = {pat_word_r[3], pat_word_r[2], pat_word_r[1], pat_word_r[0]};

  always_comb begin
    hdr_end    = HDR_W'(s1_ihl_r) + HDR_W'(UDP_HDR_BYTES);
    is_payload = byte_idx_r >= hdr_end;
    byte_idx_nxt = (&byte_idx_r) ? byte_idx_r : byte_idx_r + BIDX_W'(1);
    seen_inc   = (seen_r < SEEN_W'(MAX_PATTERN)) ? seen_r + SEEN_W'(1) : seen_r;

    // Clamp the pattern length to 1..MAX_PATTERN.
    if (pattern_len_r == '0) begin
      eff_len = PLEN_W'(1);
    end else if (pattern_len_r > PLEN_W'(MAX_PATTERN)) begin
      eff_len = PLEN_W'(MAX_PATTERN);
    end else begin
      eff_len = pattern_len_r;
    end
    len_m1 = PIDX_W'(eff_len - PLEN_W'(1));

    // Window as it stands after the new byte shifts in; position j meets pattern byte n-1-j.
    for (int j = 0; j < MAX_PATTERN; j++) begin
      nwin[j]   = (j == 0) ? s1_byte_r : win_r[(j == 0) ? 0 : j - 1];
      pidx[j]   = len_m1 - PIDX_W'(j);
      pos_ok[j] = (PLEN_W'(j) >= eff_len) ||
                  (nwin[j] == pat_flat[{pidx[j], 3'b000} +: BYTE_W]);
    end

    hit       = is_payload && (seen_inc >= SEEN_W'(eff_len)) && (&pos_ok);
    match_any = match_r || hit;

    case (filter_mode_r)
      MODE_PASS_ALL: verdict_nxt = VERDICT_CONTINUE;
      MODE_INSPECT: begin
        if (!match_any) begin
          verdict_nxt = VERDICT_NONE;
        end else if (replace_mode_r) begin
          verdict_nxt = VERDICT_CONTINUE;
        end else begin
          verdict_nxt = VERDICT_BLOCK;
        end
      end
      default:       verdict_nxt = VERDICT_BLOCK;  // no context, and the unused mode
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r <= '0;
      seen_r     <= '0;
      match_r    <= 1'b0;
    end else if (fire) begin
      if (s1_last_r) begin
        // End of packet: drop all per-packet state.
        byte_idx_r <= '0;
        seen_r     <= '0;
        match_r    <= 1'b0;
      end else begin
        byte_idx_r <= byte_idx_nxt;
        if (is_payload) begin
          seen_r <= seen_inc;
        end
        match_r <= match_any;
      end
    end
  end

  // Window entries past the payload count are never compared, so they need no clearing.
  always_ff @(posedge clk) begin
    if (fire && is_payload) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win_r[j] <= nwin[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: hold a verdict until the sink takes the transaction
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_last_r) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.verdict = verdict_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_verdict_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire && s1_last_r))
    else $error("verdict appeared without a last byte");

  a_packet_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_last_r) |=> (byte_idx_r == '0 && seen_r == '0 && !match_r))
    else $error("per-packet state not cleared after last byte");

  a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= SEEN_W'(MAX_PATTERN))
    else $error("payload count beyond window depth");

  a_mid_packet_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !s1_last_r && !out_valid_r) |=> !out_valid_r)
    else $error("verdict produced on a non-last byte");

  a_pass_all_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_last_r && filter_mode_r == MODE_PASS_ALL) |=>
      (out_valid_r && verdict_r == VERDICT_CONTINUE))
    else $error("pass mode gave a verdict other than continue");

endmodule

`default_nettype wire
